// ===== hdl/fsie_pkg.sv =====
// Shared constants and types for the format string integer expander.
package fsie_pkg;

	// Width of the signed integer argument.
	localparam int ARG_WIDTH = 32;

	// Decimal digits needed for the magnitude: ceil(ARG_WIDTH * log10(2)), rounded up safely.
	localparam int NUM_DIGITS = (ARG_WIDTH * 1233 + 4095) / 4096;
	localparam int BCD_W = 4 * NUM_DIGITS;
	localparam int CONV_CNT_W = $clog2(ARG_WIDTH);
	localparam int DIG_CNT_W = $clog2(NUM_DIGITS);

	// Input beat width: format byte plus argument, padded to whole bytes.
	localparam int S_DATA_W = ((8 + ARG_WIDTH + 7) / 8) * 8;

	// Characters with special meaning.
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_ESCAPE = 8'h24;
	localparam logic [7:0] CH_D = 8'h64;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO = 8'h30;

	// Result kinds carried on the output side.
	localparam logic [1:0] STATUS_CHAR = 2'd0;
	localparam logic [1:0] STATUS_END_OK = 2'd1;
	localparam logic [1:0] STATUS_END_ESC = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SINGLE = 4'b0010,
		ST_CONV   = 4'b0100,
		ST_EMIT   = 4'b1000
	} state_t;

endpackage

// ===== hdl/format_string_int_expander.sv =====
// Top level: printf style formatter that expands an escaped 'd' into signed decimal text.
// Flow: a plain byte waits in the single-beat register, then moves to the output register;
// an expansion runs an ARG_WIDTH (32) bit, bit-serial binary to decimal conversion, then
// emits its output beats one at a time, up to eleven, skipping any leading zero digits.
// No new byte is taken until the last result is loaded; an expansion holds the input for its whole run.
// Reset: arst_n clears the state machine, the pending escape and the output valid at once.
module format_string_int_expander
	import fsie_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // [7:0] format_byte, [ARG_WIDTH+7:8] argument
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,   // [7:0] out_char
	output logic [1:0]          m_tuser,   // [1:0] status
	output logic                m_tlast
);

	state_t                state_q;
	logic                  escape_q;
	logic [7:0]            single_char_q;
	logic [1:0]            single_status_q;

	// Conversion datapath: the magnitude shifts out MSB first into a BCD register.
	logic [ARG_WIDTH-1:0]  mag_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [CONV_CNT_W-1:0] conv_cnt_q;
	logic [DIG_CNT_W-1:0]  dig_cnt_q;
	logic                  neg_q;
	logic                  seen_q;

	// Output register: parts the result channel from the conversion logic.
	logic                  out_valid_q;
	logic [7:0]            out_char_q;
	logic [1:0]            out_status_q;
	logic                  out_last_q;

	logic [7:0]            in_byte;
	logic [ARG_WIDTH-1:0]  in_arg;
	logic                  in_neg;
	logic [ARG_WIDTH-1:0]  in_mag;
	logic                  accept;
	logic                  can_push;
	logic [BCD_W-1:0]      bcd_adj;
	logic [3:0]            top_digit;
	logic                  last_digit;

	assign in_byte = s_tdata[7:0];
	assign in_arg = s_tdata[ARG_WIDTH+7:8];
	assign in_neg = in_arg[ARG_WIDTH-1];
	// The magnitude is taken unsigned, so the most negative value converts correctly.
	assign in_mag = in_neg ? (~in_arg + {{(ARG_WIDTH-1){1'b0}}, 1'b1}) : in_arg;

	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;

	// A new beat may be loaded when the output register is empty or is being emptied.
	assign can_push = !out_valid_q || m_tready;

	// Shift-and-add-3 correction: every BCD digit of five or more gets three added
	// before the next doubling. The digits are independent of each other.
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	assign top_digit = bcd_q[BCD_W-1 -: 4];
	assign last_digit = (dig_cnt_q == DIG_CNT_W'(NUM_DIGITS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			escape_q <= 1'b0;
			single_char_q <= '0;
			single_status_q <= STATUS_CHAR;
			mag_q <= '0;
			bcd_q <= '0;
			conv_cnt_q <= '0;
			dig_cnt_q <= '0;
			neg_q <= 1'b0;
			seen_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_char_q <= '0;
			out_status_q <= STATUS_CHAR;
			out_last_q <= 1'b0;
		end else begin
			// The output beat is retired when taken; a push below overrides this.
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!escape_q) begin
							if (in_byte == CH_NUL) begin
								single_char_q <= CH_NUL;
								single_status_q <= STATUS_END_OK;
								state_q <= ST_SINGLE;
							end else if (in_byte == CH_ESCAPE) begin
								// An escape opens and produces no beat.
								escape_q <= 1'b1;
							end else begin
								single_char_q <= in_byte;
								single_status_q <= STATUS_CHAR;
								state_q <= ST_SINGLE;
							end
						end else begin
							escape_q <= 1'b0;
							if (in_byte == CH_NUL) begin
								// String ended with the escape still open.
								single_char_q <= CH_NUL;
								single_status_q <= STATUS_END_ESC;
								state_q <= ST_SINGLE;
							end else if (in_byte == CH_D) begin
								mag_q <= in_mag;
								neg_q <= in_neg;
								bcd_q <= '0;
								conv_cnt_q <= CONV_CNT_W'(ARG_WIDTH - 1);
								state_q <= ST_CONV;
							end else begin
								// Any other escaped byte is echoed, so two escapes give one.
								single_char_q <= in_byte;
								single_status_q <= STATUS_CHAR;
								state_q <= ST_SINGLE;
							end
						end
					end
				end

				ST_SINGLE: begin
					if (can_push) begin
						out_valid_q <= 1'b1;
						out_char_q <= single_char_q;
						out_status_q <= single_status_q;
						out_last_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end

				ST_CONV: begin
					// One magnitude bit enters the BCD register per cycle.
					bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[ARG_WIDTH-1]};
					mag_q <= {mag_q[ARG_WIDTH-2:0], 1'b0};
					if (conv_cnt_q == '0) begin
						dig_cnt_q <= '0;
						seen_q <= 1'b0;
						state_q <= ST_EMIT;
					end else begin
						conv_cnt_q <= conv_cnt_q - CONV_CNT_W'(1);
					end
				end

				ST_EMIT: begin
					if (neg_q) begin
						// The sign goes out ahead of the digits.
						if (can_push) begin
							out_valid_q <= 1'b1;
							out_char_q <= CH_MINUS;
							out_status_q <= STATUS_CHAR;
							out_last_q <= 1'b0;
							neg_q <= 1'b0;
						end
					end else if (!seen_q && top_digit == 4'd0 && !last_digit) begin
						// Leading zeros are dropped; the units digit always goes out.
						bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
						dig_cnt_q <= dig_cnt_q + DIG_CNT_W'(1);
					end else if (can_push) begin
						out_valid_q <= 1'b1;
						out_char_q <= CH_ZERO + {4'd0, top_digit};
						out_status_q <= STATUS_CHAR;
						out_last_q <= last_digit;
						seen_q <= 1'b1;
						bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
						if (last_digit) begin
							state_q <= ST_IDLE;
						end else begin
							dig_cnt_q <= dig_cnt_q + DIG_CNT_W'(1);
						end
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_char_q;
	assign m_tuser = out_status_q;
	assign m_tlast = out_last_q;

endmodule

// ===== tb/format_string_int_expander_tb.sv =====
// Self-checking testbench for the format string integer expander.
module format_string_int_expander_tb;
	import fsie_pkg::*;

	// Run shape. The quiet limit covers the long receiver hold-off plus a full expansion,
	// several times over; the drain count is more than one conversion and its output beats.
	localparam int RANDOM_BEATS = 280;
	localparam int PHASES = 4;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 96;
	localparam int QUIET_LIMIT = 4000;

	// One result beat as it leaves the block.
	typedef struct packed {
		logic [7:0] ch;
		logic [1:0] st;
		logic       lst;
	} fmt_result_t;

	// One row of the directed table. When typed is set, the expected output is read off the
	// row: the characters of text, or a single end beat when status is not a character.
	typedef struct {
		logic [7:0]           fb;
		logic [ARG_WIDTH-1:0] arg;
		bit                   typed;
		logic [1:0]           st;
		string                text;
	} fmt_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;   // [7:0] format_byte, [ARG_WIDTH+7:8] argument
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [7:0]          m_tdata;        // [7:0] out_char
	logic [1:0]          m_tuser;        // [1:0] status
	logic                m_tlast;

	// Side information that travels with the beat on offer, so the monitor knows at the
	// accepting edge whether the expectation is typed in or comes from the predictor.
	bit         beat_typed = 1'b0;
	logic [1:0] beat_status = STATUS_CHAR;
	string      beat_text = "";

	// Predictor state and the characters still owed by the block, oldest first.
	logic        escape_open = 1'b0;
	fmt_result_t formatted_q[$];
	int          mismatches = 0;
	int          beats_sent = 0;
	int          quiet_cycles = 0;

	// Idle and stall rates in percent, changed only between phases while the block is empty.
	int tx_gap_pct = 0;
	int rx_stall_pct = 0;

	// Long receiver hold-off: the sender bumps the request count, the receiver counts the
	// stretch out in its own process.
	int rx_hold_asked = 0;
	int rx_hold_taken = 0;
	int rx_hold_left = 0;

	fmt_row_t directed_rows[$];

	format_string_int_expander dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void queue_result(input bit keep, input logic [7:0] ch,
			input logic [1:0] st, input logic lst);
		if (keep) begin
			formatted_q.push_back('{ch, st, lst});
		end
	endfunction

	// Advances the formatter by one format byte. The escape state always moves on; the
	// resulting characters are queued only when keep is set.
	function automatic void format_step(input logic [7:0] fb, input logic [ARG_WIDTH-1:0] arg,
			input bit keep);
		logic                 neg;
		logic [ARG_WIDTH-1:0] mag;
		logic [7:0]           digs [0:23];
		int                   nd;
		nd = 0;
		if (!escape_open) begin
			if (fb == CH_NUL) begin
				queue_result(keep, CH_NUL, STATUS_END_OK, 1'b1);
			end else if (fb == CH_ESCAPE) begin
				escape_open = 1'b1;
			end else begin
				queue_result(keep, fb, STATUS_CHAR, 1'b1);
			end
		end else begin
			escape_open = 1'b0;
			if (fb == CH_NUL) begin
				queue_result(keep, CH_NUL, STATUS_END_ESC, 1'b1);
			end else if (fb == CH_D) begin
				// The magnitude is taken as an unsigned vector, so the most negative value
				// comes out right.
				neg = arg[ARG_WIDTH-1];
				mag = neg ? ~arg + 1'b1 : arg;
				do begin
					digs[nd] = CH_ZERO + 8'(mag % 10);
					mag = mag / 10;
					nd++;
				end while (mag != 0);
				if (neg) begin
					queue_result(keep, CH_MINUS, STATUS_CHAR, 1'b0);
				end
				for (int i = nd - 1; i >= 0; i--) begin
					queue_result(keep, digs[i], STATUS_CHAR, i == 0);
				end
			end else begin
				queue_result(keep, fb, STATUS_CHAR, 1'b1);
			end
		end
	endfunction

	// Queues the output that a directed row spells out by hand.
	function automatic void queue_typed(input logic [1:0] st, input string text);
		if (st == STATUS_CHAR) begin
			for (int i = 0; i < text.len(); i++) begin
				formatted_q.push_back('{text[i], STATUS_CHAR, i == text.len() - 1});
			end
		end else begin
			formatted_q.push_back('{CH_NUL, st, 1'b1});
		end
	endfunction

	// Arguments spread over all digit counts, both signs and the extremes; the full random
	// case exercises every bit.
	function automatic logic [ARG_WIDTH-1:0] random_arg();
		logic [ARG_WIDTH-1:0] v;
		case ($urandom_range(0, 4))
			0: begin
				v = $urandom;
			end
			1: begin
				v = $urandom_range(0, 9);
			end
			2: begin
				v = $urandom_range(1, 99);
				v = -v;
			end
			3: begin
				v = $urandom >> $urandom_range(0, ARG_WIDTH - 1);
				if ($urandom_range(0, 1) == 1) begin
					v = -v;
				end
			end
			default: begin
				case ($urandom_range(0, 3))
					0: v = {1'b1, {(ARG_WIDTH-1){1'b0}}};
					1: v = {1'b0, {(ARG_WIDTH-1){1'b1}}};
					2: v = '0;
					default: v = '1;
				endcase
			end
		endcase
		return v;
	endfunction

	// Offers one beat starting at the next falling edge and returns at the rising edge that
	// takes it. tvalid stays high from one beat to the next unless an idle gap is drawn.
	task automatic send_beat(input logic [7:0] fb, input logic [ARG_WIDTH-1:0] arg,
			input bit typed, input logic [1:0] st, input string text);
		logic [S_DATA_W-1:0] word;
		word = '0;
		word[7:0] = fb;
		word[ARG_WIDTH+7:8] = arg;
		@(negedge clk);
		while (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		beat_typed <= typed;
		beat_status <= st;
		beat_text <= text;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		beats_sent++;
	endtask

	// Stops offering and waits until every owed character has come out, then lines up on a
	// rising edge so that rate changes never race the falling-edge drivers.
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (formatted_q.size() == 0);
		@(posedge clk);
	endtask

	// One short random sequence. Most are well formed: plain text, an escaped integer, an
	// escaped literal, a terminator. A few are a dangling escape or a byte drawn from the
	// whole range, which may open or close an escape at random.
	task automatic send_random_seq();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			send_beat(8'($urandom_range(1, 255)), $urandom, 1'b0, STATUS_CHAR, "");
		end else if (pick < 75) begin
			send_beat(CH_ESCAPE, $urandom, 1'b0, STATUS_CHAR, "");
			send_beat(CH_D, random_arg(), 1'b0, STATUS_CHAR, "");
		end else if (pick < 85) begin
			send_beat(CH_ESCAPE, $urandom, 1'b0, STATUS_CHAR, "");
			send_beat(8'($urandom_range(1, 255)), $urandom, 1'b0, STATUS_CHAR, "");
		end else if (pick < 93) begin
			send_beat(CH_NUL, $urandom, 1'b0, STATUS_CHAR, "");
		end else if (pick < 97) begin
			send_beat(CH_ESCAPE, $urandom, 1'b0, STATUS_CHAR, "");
			send_beat(CH_NUL, $urandom, 1'b0, STATUS_CHAR, "");
		end else begin
			send_beat(8'($urandom_range(0, 255)), $urandom, 1'b0, STATUS_CHAR, "");
		end
	endtask

	// Receiver: tready is redrawn at every falling edge, or held low through a requested
	// hold-off so that the block backs up and stops taking input.
	always @(negedge clk) begin
		if (rx_hold_asked != rx_hold_taken) begin
			rx_hold_taken = rx_hold_asked;
			rx_hold_left = RX_HOLD_CYCLES;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
		end
	end

	// Monitor: checks each output beat against the oldest owed character, then predicts the
	// output of any input beat taken at the same edge. An input beat can never produce its
	// output at the edge that accepts it, so this order is safe.
	always @(posedge clk) begin
		fmt_result_t want;
		if (m_tvalid && m_tready) begin
			if (formatted_q.size() == 0) begin
				$error("result beat with nothing owed: out_char %02h status %0d last %0b",
					m_tdata, m_tuser, m_tlast);
				mismatches++;
			end else begin
				want = formatted_q.pop_front();
				if (m_tdata !== want.ch) begin
					$error("out_char: expected %02h, got %02h", want.ch, m_tdata);
					mismatches++;
				end
				if (m_tuser !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, m_tuser);
					mismatches++;
				end
				if (m_tlast !== want.lst) begin
					$error("last: expected %0b, got %0b", want.lst, m_tlast);
					mismatches++;
				end
			end
		end
		if (s_tvalid && s_tready) begin
			format_step(s_tdata[7:0], s_tdata[ARG_WIDTH+7:8], !beat_typed);
			if (beat_typed) begin
				queue_typed(beat_status, beat_text);
			end
		end
	end

	// Watchdog: ends the run when neither side has moved a beat for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("format_string_int_expander_tb: FAIL");
			$finish;
		end
	end

	initial begin
		int phase_start;
		// Directed table. Rows with a typed expectation cover the empty string right after
		// reset, an unescaped d, the zero argument, both integer extremes, minus one, the
		// doubled escape, an escape before an ordinary byte and a dangling escape.
		directed_rows.push_back('{CH_NUL, '0, 1'b1, STATUS_END_OK, ""});
		directed_rows.push_back('{8'h48, '1, 1'b1, STATUS_CHAR, "H"});
		directed_rows.push_back('{8'hFF, '0, 1'b0, STATUS_CHAR, ""});
		directed_rows.push_back('{CH_D, 32'd5, 1'b1, STATUS_CHAR, "d"});
		directed_rows.push_back('{CH_ESCAPE, '1, 1'b1, STATUS_CHAR, ""});
		directed_rows.push_back('{CH_D, '0, 1'b1, STATUS_CHAR, "0"});
		directed_rows.push_back('{CH_ESCAPE, '0, 1'b1, STATUS_CHAR, ""});
		directed_rows.push_back('{CH_D, 32'h8000_0000, 1'b1, STATUS_CHAR, "-2147483648"});
		directed_rows.push_back('{CH_ESCAPE, '0, 1'b1, STATUS_CHAR, ""});
		directed_rows.push_back('{CH_D, 32'h7FFF_FFFF, 1'b1, STATUS_CHAR, "2147483647"});
		directed_rows.push_back('{CH_ESCAPE, '0, 1'b1, STATUS_CHAR, ""});
		directed_rows.push_back('{CH_D, 32'hFFFF_FFFF, 1'b1, STATUS_CHAR, "-1"});
		directed_rows.push_back('{CH_ESCAPE, '0, 1'b0, STATUS_CHAR, ""});
		directed_rows.push_back('{CH_D, 32'd1000000000, 1'b0, STATUS_CHAR, ""});
		directed_rows.push_back('{CH_ESCAPE, '0, 1'b1, STATUS_CHAR, ""});
		directed_rows.push_back('{CH_ESCAPE, '0, 1'b1, STATUS_CHAR, "$"});
		directed_rows.push_back('{CH_ESCAPE, '0, 1'b1, STATUS_CHAR, ""});
		directed_rows.push_back('{8'h78, '0, 1'b1, STATUS_CHAR, "x"});
		directed_rows.push_back('{CH_ESCAPE, '0, 1'b0, STATUS_CHAR, ""});
		directed_rows.push_back('{8'hFF, 32'h5555_5555, 1'b0, STATUS_CHAR, ""});
		directed_rows.push_back('{CH_ESCAPE, '0, 1'b1, STATUS_CHAR, ""});
		directed_rows.push_back('{CH_NUL, '1, 1'b1, STATUS_END_ESC, ""});
		directed_rows.push_back('{CH_NUL, '0, 1'b1, STATUS_END_OK, ""});

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			send_beat(directed_rows[i].fb, directed_rows[i].arg, directed_rows[i].typed,
				directed_rows[i].st, directed_rows[i].text);
		end
		drain_results();

		// Random part in four phases: no idling, sender gaps, receiver stalls, then both.
		// The first phase also holds the receiver off for a long stretch while the sender
		// keeps offering. Each phase ends with the sender waiting for every owed character.
		for (int ph = 0; ph < PHASES; ph++) begin
			tx_gap_pct = (ph == 1) ? 49 : (ph == 3) ? 14 : 0;
			rx_stall_pct = (ph == 2) ? 49 : (ph == 3) ? 14 : 0;
			phase_start = beats_sent;
			while (beats_sent - phase_start < RANDOM_BEATS / PHASES) begin
				send_random_seq();
				if (ph == 0 && rx_hold_asked == 0 && beats_sent - phase_start >= 4) begin
					rx_hold_asked++;
				end
			end
			drain_results();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && formatted_q.size() == 0) begin
			$display("format_string_int_expander_tb: PASS");
		end else begin
			$display("format_string_int_expander_tb: FAIL");
		end
		$finish;
	end

endmodule

// ===== format_string_int_expander.f =====
hdl/fsie_pkg.sv
hdl/format_string_int_expander.sv
tb/format_string_int_expander_tb.sv
